// ===== rtl/ckse_pkg.sv =====
// ----------------------------------------------------------------------------
// Checksum engine package
// Types, constants and the sum folding function shared by the checksum
// engine's modules and interfaces.
// ----------------------------------------------------------------------------
package ckse_pkg;

	// Word and sum widths.
	localparam int unsigned WordW = 16;
	localparam int unsigned SumW  = 32;

	// Header layout constants.
	localparam logic [3:0]  MinIhl        = 4'd5;
	localparam logic [15:0] IpCsumWord    = 16'd5;
	localparam logic [15:0] FirstAddrWord = 16'd6;
	localparam logic [15:0] LastAddrWord  = 16'd9;
	localparam logic [15:0] TcpCsumSegWord = 16'd8;
	localparam logic [15:0] PosMax        = 16'hFFFF;
	localparam logic [31:0] ProtoTcp      = 32'd6;

	// One incoming packet word.
	typedef struct packed {
		logic [WordW-1:0] packet_word;
		logic             only_high_byte;
		logic             last_word;
	} ckse_item_t;

	// One result word.
	typedef struct packed {
		logic [WordW-1:0] ip_header_checksum;
		logic [WordW-1:0] tcp_segment_checksum;
		logic             ended_short;
	} ckse_result_t;

	// Unfolded sums handed from the accumulator to the folding stage.
	typedef struct packed {
		logic [SumW-1:0] ip_sum;
		logic [SumW-1:0] tcp_sum;
		logic            ended_short;
	} ckse_final_t;

	// Fold a 32-bit sum twice into 16 bits and complement it.
	function automatic logic [WordW-1:0] fold_not(input logic [SumW-1:0] s);
		logic [WordW:0] a;
		logic [WordW:0] b;
		a = {1'b0, s[WordW-1:0]} + {1'b0, s[SumW-1:WordW]};
		b = {1'b0, a[WordW-1:0]} + {{WordW{1'b0}}, a[WordW]};
		return ~b[WordW-1:0];
	endfunction

endpackage

// ===== rtl/ckse_pkt_if.sv =====
// ----------------------------------------------------------------------------
// Packet word channel
// Valid/ready channel carrying one packet word with its end marks.
// ----------------------------------------------------------------------------
interface ckse_pkt_if;
	logic                valid;
	logic                ready;
	ckse_pkg::ckse_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/ckse_csum_if.sv =====
// ----------------------------------------------------------------------------
// Checksum result channel
// Valid/ready channel carrying the two checksums and the short packet flag.
// ----------------------------------------------------------------------------
interface ckse_csum_if;
	logic                  valid;
	logic                  ready;
	ckse_pkg::ckse_result_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/ckse_accum.sv =====
// ----------------------------------------------------------------------------
// Checksum accumulator
// Tracks the word position and header fields of the current packet, adds each
// word into the IP and TCP running sums and, on the last word, registers the
// unfolded totals for the folding stage.
// ----------------------------------------------------------------------------
module ckse_accum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  ckse_pkg::ckse_item_t item,
	output logic                 item_ready,
	output logic                 fin_valid,
	output ckse_pkg::ckse_final_t fin,
	input  logic                 fin_ready
);

	logic [15:0] word_position_q;
	logic [3:0]  hlw_q;
	logic [15:0] seglen_q;
	logic [31:0] hsum_q;
	logic [31:0] ssum_q;

	logic                  valid_s2;
	ckse_pkg::ckse_final_t final_s2;

	logic        take;
	logic [15:0] w;
	logic [3:0]  ihl;
	logic [3:0]  hlw_new;
	logic [4:0]  hwords;
	logic [5:0]  hbytes;
	logic [15:0] seglen_new;
	logic        in_header;
	logic [15:0] sw;
	logic [17:0] off;
	logic [15:0] hdr_add;
	logic [15:0] seg_add;
	logic [31:0] hsum_new;
	logic [31:0] ssum_new;
	logic [17:0] bytes;
	logic        short_flag;
	logic [31:0] tcp_total;

	// A last word may only pass when the result register can take its totals.
	assign item_ready = !item.last_word || !valid_s2 || fin_ready;
	assign take       = item_valid && item_ready;

	// Per-word decode and sum contributions.
	always_comb begin
		w = item.only_high_byte ? {item.packet_word[15:8], 8'h00} : item.packet_word;
		ihl = w[11:8];
		if (word_position_q == 16'd0) begin
			hlw_new = (ihl < ckse_pkg::MinIhl) ? ckse_pkg::MinIhl : ihl;
		end else begin
			hlw_new = hlw_q;
		end
		hwords = {hlw_new, 1'b0};
		hbytes = {hlw_new, 2'b00};

		if (word_position_q == 16'd1) begin
			seglen_new = (w >= {10'd0, hbytes}) ? (w - {10'd0, hbytes}) : 16'd0;
		end else begin
			seglen_new = seglen_q;
		end

		in_header = word_position_q < {11'd0, hwords};
		sw        = word_position_q - {11'd0, hwords};
		off       = {1'b0, sw, 1'b0};

		hdr_add = 16'd0;
		seg_add = 16'd0;
		if (in_header) begin
			if (word_position_q != ckse_pkg::IpCsumWord) begin
				hdr_add = w;
			end
			if (word_position_q >= ckse_pkg::FirstAddrWord &&
			    word_position_q <= ckse_pkg::LastAddrWord) begin
				seg_add = w;
			end
		end else if (sw != ckse_pkg::TcpCsumSegWord) begin
			// Past the header the segment length is already settled.
			if (off + 18'd2 <= {2'd0, seglen_q}) begin
				seg_add = w;
			end else if (off + 18'd1 == {2'd0, seglen_q}) begin
				seg_add = {w[15:8], 8'h00};
			end
		end

		hsum_new = hsum_q + {16'd0, hdr_add};
		ssum_new = ssum_q + {16'd0, seg_add};

		// Byte count seen, and totals for the end of the packet.
		bytes      = {1'b0, word_position_q, 1'b0} + 18'd2 - {17'd0, item.only_high_byte};
		short_flag = bytes < ({12'd0, hbytes} + {2'd0, seglen_new});
		tcp_total  = ssum_new + ckse_pkg::ProtoTcp + {16'd0, seglen_new};
	end

	// Packet state: cleared after the last word ready for the next packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_position_q <= 16'd0;
			hlw_q           <= 4'd0;
			seglen_q        <= 16'd0;
			hsum_q          <= 32'd0;
			ssum_q          <= 32'd0;
		end else if (take) begin
			if (item.last_word) begin
				word_position_q <= 16'd0;
				hlw_q           <= 4'd0;
				seglen_q        <= 16'd0;
				hsum_q          <= 32'd0;
				ssum_q          <= 32'd0;
			end else begin
				if (word_position_q != ckse_pkg::PosMax) begin
					word_position_q <= word_position_q + 16'd1;
				end
				hlw_q    <= hlw_new;
				seglen_q <= seglen_new;
				hsum_q   <= hsum_new;
				ssum_q   <= ssum_new;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take && item.last_word) begin
			valid_s2 <= 1'b1;
		end else if (fin_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (take && item.last_word) begin
			final_s2.ip_sum      <= hsum_new;
			final_s2.tcp_sum     <= tcp_total;
			final_s2.ended_short <= short_flag;
		end
	end

	assign fin_valid = valid_s2;
	assign fin       = final_s2;

`ifndef NO_ASSERTIONS
	// The last word of a packet clears the position and raises a result.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.last_word |=> word_position_q == 16'd0 && valid_s2)
		else $error("last word did not clear state or raise a result");

	// Once set, the header length is never below the minimum.
	a_hlw_min: assert property (@(posedge clk) disable iff (!arst_n)
		hlw_q != 4'd0 |-> hlw_q >= ckse_pkg::MinIhl)
		else $error("header length below minimum");

	// At the start of a packet every running value is zero.
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		word_position_q == 16'd0 |->
			hlw_q == 4'd0 && seglen_q == 16'd0 && hsum_q == 32'd0 && ssum_q == 32'd0)
		else $error("packet state not clean at packet start");

	// A waiting result is neither lost nor altered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !fin_ready |=> valid_s2 && $stable(final_s2))
		else $error("pending result dropped or changed");
`endif

endmodule

// ===== rtl/ckse_fold.sv =====
// ----------------------------------------------------------------------------
// Checksum folding stage
// Folds both end-of-packet sums to 16 bits, complements them and holds the
// result word in the output register until it is taken.
// ----------------------------------------------------------------------------
module ckse_fold (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fin_valid,
	input  ckse_pkg::ckse_final_t fin,
	output logic                  fin_ready,
	ckse_csum_if.source           csum
);

	logic                   valid_q;
	ckse_pkg::ckse_result_t result_q;

	// The output register takes a new word when empty or being emptied.
	assign fin_ready = !valid_q || csum.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fin_ready) begin
			valid_q <= fin_valid;
		end
	end

	// Fold and complement into the output register.
	always_ff @(posedge clk) begin
		if (fin_ready && fin_valid) begin
			result_q.ip_header_checksum   <= ckse_pkg::fold_not(fin.ip_sum);
			result_q.tcp_segment_checksum <= ckse_pkg::fold_not(fin.tcp_sum);
			result_q.ended_short          <= fin.ended_short;
		end
	end

	assign csum.valid   = valid_q;
	assign csum.payload = result_q;

endmodule

// ===== rtl/ipv4_tcp_checksum_engine_core.sv =====
// ----------------------------------------------------------------------------
// IPv4 / TCP checksum engine
// Computes the IPv4 header checksum and the TCP checksum with pseudo header
// over a packet streamed as 16-bit network order words.
// ----------------------------------------------------------------------------
// The engine takes one packet word per cycle, with no gap between packets,
// except while a last word waits on a full result path, and gives one result
// word for each word marked last. Each word passes an input register and is
// added into the running sums; a last word's totals go into the result
// register, and the folding stage feeds the output register from there.
// The input keeps accepting words while a finished result waits; only a last
// word waits on a full result path. The header length comes from the first
// word, an IHL below five being treated as five, and the segment length from
// the second; words beyond the segment are ignored and an odd final byte is
// padded with a zero low byte.
// ----------------------------------------------------------------------------
module ipv4_tcp_checksum_engine_core (
	input  logic      clk,
	input  logic      arst_n,
	ckse_pkt_if.sink  pkt,
	ckse_csum_if.source csum
);

	logic                  valid_s1;
	ckse_pkg::ckse_item_t  item_s1;
	logic                  item_ready;
	logic                  fin_valid;
	ckse_pkg::ckse_final_t fin;
	logic                  fin_ready;

	// Input register: refilled whenever its word moves on.
	assign pkt.ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			item_s1 <= pkt.payload;
		end
	end

	// Running sums and packet state.
	ckse_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.item_ready (item_ready),
		.fin_valid  (fin_valid),
		.fin        (fin),
		.fin_ready  (fin_ready)
	);

	// Folding and output register.
	ckse_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin       (fin),
		.fin_ready (fin_ready),
		.csum      (csum)
	);

endmodule

// ===== bench/tb_ipv4_tcp_checksum_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IPv4 / TCP checksum engine
// Streams IPv4 packets into the engine word by word and checks every result
// word against a cycle-free model of the two checksums and the short flag.
// A short directed table comes first, then random packets that are mostly
// well formed. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_ipv4_tcp_checksum_engine_core;

	localparam int ClkPeriod     = 10;
	localparam int ResetCycles   = 7;
	localparam int MaxIdle       = 11;
	localparam int RandomWords   = 470;
	localparam int RandomPackets = 36;
	localparam int DrainCycles   = 8;
	localparam int WatchdogLimit = 1000;
	localparam int ReportLimit   = 10;

	// One row of the directed table, with an optional hand-worked result.
	typedef struct {
		ckse_pkg::ckse_item_t   item;
		bit                     known;
		ckse_pkg::ckse_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ckse_pkt_if  pkt_ch ();
	ckse_csum_if csum_ch ();

	ipv4_tcp_checksum_engine_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.csum   (csum_ch)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// Checksums still owed by the engine, oldest first.
	ckse_pkg::ckse_result_t csum_expected[$];
	stim_row_t              stim_table[$];
	ckse_pkg::ckse_item_t   pkt_words[$];
	int                     mismatch_count = 0;

	// Running state of the checksum model.
	logic [15:0] pred_pos     = '0;
	logic [3:0]  pred_ihl     = '0;
	logic [15:0] pred_seg_len = '0;
	logic [31:0] pred_ip_sum  = '0;
	logic [31:0] pred_tcp_sum = '0;

	// Fold a 32-bit one's complement sum to 16 bits twice and invert it.
	function automatic logic [15:0] fold_and_invert(input logic [31:0] s);
		logic [31:0] t;
		t = {16'h0, s[15:0]} + {16'h0, s[31:16]};
		t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
		return ~t[15:0];
	endfunction

	// Advance the checksum model by one accepted word. Returns 1 when the word
	// closes a packet, with the checksums that the engine must give for it.
	function automatic bit checksum_predict(input ckse_pkg::ckse_item_t it,
			output ckse_pkg::ckse_result_t res);
		logic [15:0] w;
		logic [31:0] tcp;
		int unsigned pos;
		int unsigned hwords;
		int unsigned hbytes;
		int unsigned seg_word;
		int unsigned offset;
		int unsigned bytes;
		w = it.packet_word;
		if (it.only_high_byte) begin
			w = w & 16'hFF00;
		end
		pos = pred_pos;
		res = '0;

		// The first word gives the header length, never below five.
		if (pos == 0) begin
			pred_ihl = (w[11:8] < ckse_pkg::MinIhl) ? ckse_pkg::MinIhl : w[11:8];
		end
		hwords = pred_ihl * 32'd2;
		hbytes = pred_ihl * 32'd4;

		// The second word gives the total length, hence the segment length.
		if (pos == 1) begin
			pred_seg_len = (w >= hbytes) ? 16'(w - hbytes) : 16'd0;
		end

		if (pos < hwords) begin
			if (pos != ckse_pkg::IpCsumWord) begin
				pred_ip_sum += w;
			end
			if (pos >= ckse_pkg::FirstAddrWord && pos <= ckse_pkg::LastAddrWord) begin
				pred_tcp_sum += w;
			end
		end else begin
			// Segment words, with the odd final byte padded and the rest ignored.
			seg_word = pos - hwords;
			offset   = seg_word * 2;
			if (seg_word != ckse_pkg::TcpCsumSegWord) begin
				if (offset + 2 <= pred_seg_len) begin
					pred_tcp_sum += w;
				end else if (offset + 1 == pred_seg_len) begin
					pred_tcp_sum += {w[15:8], 8'h00};
				end
			end
		end

		if (pred_pos < ckse_pkg::PosMax) begin
			pred_pos++;
		end
		if (!it.last_word) begin
			return 1'b0;
		end

		bytes = (pos + 1) * 2 - (it.only_high_byte ? 1 : 0);
		tcp   = pred_tcp_sum + ckse_pkg::ProtoTcp + {16'h0, pred_seg_len};
		res.ip_header_checksum   = fold_and_invert(pred_ip_sum);
		res.tcp_segment_checksum = fold_and_invert(tcp);
		res.ended_short          = (bytes < hbytes) || (bytes < hbytes + pred_seg_len);

		// The next packet starts from the reset state.
		pred_pos     = '0;
		pred_ihl     = '0;
		pred_seg_len = '0;
		pred_ip_sum  = '0;
		pred_tcp_sum = '0;
		return 1'b1;
	endfunction

	function automatic stim_row_t mk_row(input logic [15:0] w, input bit half, input bit last,
			input bit known = 1'b0, input ckse_pkg::ckse_result_t want = '0);
		stim_row_t row;
		row.item.packet_word    = w;
		row.item.only_high_byte = half;
		row.item.last_word      = last;
		row.known               = known;
		row.want                = want;
		return row;
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, MaxIdle);
	endfunction

	// Offer one word after an idle gap and wait until the engine takes it.
	task automatic send_word(input ckse_pkg::ckse_item_t it, input int gap, output bit has,
			output ckse_pkg::ckse_result_t res);
		if (gap > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_ch.valid   <= 1'b1;
		pkt_ch.payload <= it;
		@(posedge clk);
		while (!pkt_ch.ready) @(posedge clk);
		has = checksum_predict(it, res);
	endtask

	// Send the packet held in pkt_words and record the checksums it owes.
	task automatic send_packet(input bit burst);
		bit                     has;
		ckse_pkg::ckse_result_t res;
		foreach (pkt_words[i]) begin
			send_word(pkt_words[i], draw_gap(burst), has, res);
			if (has) begin
				csum_expected.push_back(res);
			end
		end
	endtask

	// Build one random packet: mostly well formed with random content, the rest
	// cut short, with a total length below the header, or plain noise.
	task automatic gen_packet();
		int                   kind;
		int                   ihl_field;
		int                   hbytes;
		int                   total;
		int                   extra;
		int                   n;
		logic [15:0]          w;
		ckse_pkg::ckse_item_t it;
		pkt_words.delete();
		kind      = $urandom_range(0, 9);
		ihl_field = ($urandom_range(0, 1) == 0) ? 5 : $urandom_range(0, 15);
		hbytes    = ((ihl_field < 5) ? 5 : ihl_field) * 4;
		extra     = 0;
		if (kind == 8) begin
			total = $urandom_range(0, hbytes - 1);
		end else begin
			total = hbytes + $urandom_range(0, 24);
			if (kind < 7 && $urandom_range(0, 3) == 0) begin
				extra = $urandom_range(1, 3);
			end
		end
		n = (total + 1) / 2 + extra;
		if (kind == 7) begin
			n = $urandom_range(1, n);
		end else if (kind == 9) begin
			n = $urandom_range(1, 30);
		end
		for (int i = 0; i < n; i++) begin
			w = 16'($urandom);
			it.only_high_byte = 1'b0;
			it.last_word      = (i == n - 1);
			if (kind == 9) begin
				it.only_high_byte = 1'($urandom_range(0, 1));
			end else if (i == 0) begin
				w[15:8] = {4'h4, 4'(ihl_field)};
			end else if (i == 1) begin
				w = 16'(total);
			end
			if (it.last_word && kind != 9) begin
				if (kind == 7) begin
					it.only_high_byte = 1'($urandom_range(0, 1));
				end else begin
					it.only_high_byte = (total % 2 == 1) && (extra == 0);
				end
			end
			it.packet_word = w;
			pkt_words.push_back(it);
		end
	endtask

	// Compare one result word with the oldest checksum still owed.
	task automatic check_result(input ckse_pkg::ckse_result_t got);
		ckse_pkg::ckse_result_t want;
		if (csum_expected.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= ReportLimit) begin
				$display("unexpected result: ip %h tcp %h short %b",
					got.ip_header_checksum, got.tcp_segment_checksum, got.ended_short);
			end
		end else begin
			want = csum_expected.pop_front();
			if (got.ip_header_checksum !== want.ip_header_checksum ||
					got.tcp_segment_checksum !== want.tcp_segment_checksum ||
					got.ended_short !== want.ended_short) begin
				mismatch_count++;
				if (mismatch_count <= ReportLimit) begin
					$display("mismatch: expected ip %h tcp %h short %b, got ip %h tcp %h short %b",
						want.ip_header_checksum, want.tcp_segment_checksum, want.ended_short,
						got.ip_header_checksum, got.tcp_segment_checksum, got.ended_short);
				end
			end
		end
	endtask

	// Result side: take result words after random stalls, with runs of none.
	initial begin : result_sink
		int stall;
		bit burst;
		csum_ch.ready = 1'b0;
		burst = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 7) == 0) begin
				burst = !burst;
			end
			stall = draw_gap(burst);
			if (stall > 0) begin
				csum_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			csum_ch.ready <= 1'b1;
			@(posedge clk);
			while (!csum_ch.valid) @(posedge clk);
			check_result(csum_ch.payload);
		end
	end

	// Ends the run when neither channel has moved a word for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WatchdogLimit) begin
			@(posedge clk);
			if ((pkt_ch.valid && pkt_ch.ready) || (csum_ch.valid && csum_ch.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("status: fail");
		$finish;
	end

	// Packet side: reset, directed table, random packets, drain.
	initial begin : packet_source
		bit                     has;
		bit                     burst;
		ckse_pkg::ckse_result_t res;
		int                     rand_words;
		int                     rand_packets;
		arst_n         = 1'b0;
		pkt_ch.valid   = 1'b0;
		pkt_ch.payload = '0;

		// Single-word packets whose checksums follow at a glance: the header
		// length comes from the word, nothing else arrives, so every one is short.
		stim_table.push_back(mk_row(16'h4500, 1'b0, 1'b1, 1'b1,
			ckse_pkg::ckse_result_t'{16'hBAFF, 16'hFFF9, 1'b1}));
		stim_table.push_back(mk_row(16'hFFFF, 1'b0, 1'b1, 1'b1,
			ckse_pkg::ckse_result_t'{16'h0000, 16'hFFF9, 1'b1}));
		stim_table.push_back(mk_row(16'hFFFF, 1'b1, 1'b1, 1'b1,
			ckse_pkg::ckse_result_t'{16'h00FF, 16'hFFF9, 1'b1}));

		// A full packet with an IHL of three taken as five and a 19-byte
		// segment. Both checksum fields carry junk that must be ignored; the
		// odd last segment byte comes on a half word that is not the last one,
		// and the final word lies past the segment.
		stim_table.push_back(mk_row(16'h4300, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h0027, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h1C46, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h4000, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h4006, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'hBEEF, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'hC0A8, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h0001, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'hC0A8, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h00C7, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h0050, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'hD431, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'hFFFF, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h0000, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h1234, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h5678, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h5012, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h7210, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'hA5A5, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'hABCD, 1'b1, 1'b0));
		stim_table.push_back(mk_row(16'h9999, 1'b0, 1'b1));

		// A total length below the header length gives an empty segment.
		stim_table.push_back(mk_row(16'h46FF, 1'b0, 1'b0));
		stim_table.push_back(mk_row(16'h0010, 1'b0, 1'b1));

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;

		burst = 1'b0;
		foreach (stim_table[i]) begin
			if ($urandom_range(0, 3) == 0) begin
				burst = !burst;
			end
			send_word(stim_table[i].item, draw_gap(burst), has, res);
			if (has) begin
				csum_expected.push_back(stim_table[i].known ? stim_table[i].want : res);
			end
		end

		// Hold off until every owed checksum has come back.
		pkt_ch.valid <= 1'b0;
		while (csum_expected.size() != 0) @(posedge clk);

		// Random packets until enough words and results have gone through.
		rand_words   = 0;
		rand_packets = 0;
		while (rand_words < RandomWords || rand_packets < RandomPackets) begin
			gen_packet();
			send_packet($urandom_range(0, 3) == 0);
			rand_words += pkt_words.size();
			rand_packets++;
		end

		// Drain the result path and allow the pipeline to settle.
		pkt_ch.valid <= 1'b0;
		while (csum_expected.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ckse_pkg.sv
rtl/ckse_pkt_if.sv
rtl/ckse_csum_if.sv
rtl/ckse_accum.sv
rtl/ckse_fold.sv
rtl/ipv4_tcp_checksum_engine_core.sv
bench/tb_ipv4_tcp_checksum_engine_core.sv
